>>> hw/rtl/bmmb_pkg.sv
package bmmb_pkg;

  localparam int unsigned ROM_BYTES       = 32768;
  localparam int unsigned VRAM_BANK_BYTES = 8192;
  localparam int unsigned WRAM_BANK_BYTES = 4096;
  localparam int unsigned WRAM_BANKS      = 8;
  localparam int unsigned OAM_BYTES       = 160;
  localparam int unsigned IO_BYTES        = 128;
  localparam int unsigned HRAM_BYTES      = 127;

  localparam int unsigned ROM_AW  = $clog2(ROM_BYTES);
  localparam int unsigned VRAM_AW = $clog2(2 * VRAM_BANK_BYTES);
  localparam int unsigned WRAM_AW = $clog2(WRAM_BANKS * WRAM_BANK_BYTES);
  localparam int unsigned OAM_AW  = $clog2(OAM_BYTES);
  localparam int unsigned IO_AW   = $clog2(IO_BYTES);

  // address map boundaries
  localparam logic [15:0] VRAM_BASE  = 16'h8000;
  localparam logic [15:0] EXT_BASE   = 16'hA000;
  localparam logic [15:0] WRAM_BASE  = 16'hC000;
  localparam logic [15:0] ECHO_END   = 16'hFDFF;
  localparam logic [15:0] OAM_END    = 16'hFE9F;
  localparam logic [15:0] EMPTY_END  = 16'hFEFF;
  localparam logic [15:0] IO_END     = 16'hFF7F;
  localparam logic [15:0] HRAM_END   = 16'hFFFE;
  localparam logic [15:0] VID_FIRST  = 16'hFF40;
  localparam logic [15:0] VID_LAST   = 16'hFF4B;

  localparam logic [IO_AW-1:0] IO_DIV   = 7'h04;
  localparam logic [IO_AW-1:0] IO_VBK   = 7'h4F;
  localparam logic [IO_AW-1:0] IO_SVBK  = 7'h70;

  localparam logic [7:0] OPEN_BUS = 8'hFF;

  localparam logic CFG_VIDEO_ATTACHED = 1'b0;
  localparam logic CFG_ROM_LENGTH     = 1'b1;

  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_LOAD  = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    RG_ROM, RG_VRAM, RG_EXT, RG_WRAM, RG_OAM, RG_EMPTY, RG_IO, RG_HRAM, RG_IE
  } region_t;

  typedef enum logic [2:0] {
    SRC_IMM, SRC_ROM, SRC_VRAM, SRC_WRAM, SRC_OAM, SRC_IO, SRC_HRAM
  } src_t;

  // what the read stage needs to form a result item
  typedef struct packed {
    src_t       src;
    logic [7:0] imm;
    logic       vid_access;
    logic       vid_write;
    logic [3:0] vid_reg;
    logic [7:0] vid_wdata;
  } s1_info_t;

  function automatic region_t decode_region(input logic [15:0] a);
    region_t rg;
    if (a < VRAM_BASE)       rg = RG_ROM;
    else if (a < EXT_BASE)   rg = RG_VRAM;
    else if (a < WRAM_BASE)  rg = RG_EXT;
    else if (a <= ECHO_END)  rg = RG_WRAM;
    else if (a <= OAM_END)   rg = RG_OAM;
    else if (a <= EMPTY_END) rg = RG_EMPTY;
    else if (a <= IO_END)    rg = RG_IO;
    else if (a <= HRAM_END)  rg = RG_HRAM;
    else                     rg = RG_IE;
    return rg;
  endfunction

endpackage

>>> hw/rtl/banked_memory_map_bus.sv
// Banked memory map bus: address decoder and storage for an 8-bit console map.
//
// Input channel in_*: in_tuser carries the access kind (read, write, ROM load),
// in_tdata carries the address and the write byte. Every accepted item gives
// exactly one result item on out_*, in order: read data, or the video-port
// fields for accesses to 0xFF40-0xFF4B when a video unit is attached.
// Configuration (video_attached, rom_length) is written through cfg_*; the user must write
// it only with no items in flight (not enforced by the block); cfg_ready is always high.
//
// Throughput: one item per cycle while the receiver keeps taking results. A result
// passes the registered read of the storage arrays (read stage) and then the
// output register before out_tvalid rises. Stores and bank selects take effect
// at the acceptance edge, so the next item already sees them.
// When the receiver stalls, the read stage and the output register fill and
// in_tready drops; nothing is lost or repeated.
// Reset sets the VRAM bank to 0 and the WRAM bank to 1 and clears IE, config and the
// valid bits of OAM, I/O and HRAM (these read zero until written). ROM, VRAM and WRAM
// are not cleared and need no clearing pass; they may only be read after being written.
module banked_memory_map_bus
  import bmmb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [15:0] addr, [23:16] wdata
  input  logic [1:0]  in_tuser,   // [1:0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] rdata, [11:8] video_reg, [19:12] video_wdata, 0 pad
  output logic [1:0]  out_tuser,  // [0] video_access, [1] video_is_write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  logic [7:0] rom_mem  [0:ROM_BYTES-1];
  logic [7:0] vram_mem [0:2*VRAM_BANK_BYTES-1];
  logic [7:0] wram_mem [0:WRAM_BANKS*WRAM_BANK_BYTES-1];
  logic [7:0] oam_mem  [0:OAM_BYTES-1];
  logic [7:0] io_mem   [0:IO_BYTES-1];
  logic [7:0] hram_mem [0:HRAM_BYTES-1];

  logic [OAM_BYTES-1:0]  oam_vld_r;
  logic [IO_BYTES-1:0]   io_vld_r;
  logic [HRAM_BYTES-1:0] hram_vld_r;

  logic [7:0]  rom_rd_r, vram_rd_r, wram_rd_r, oam_rd_r, io_rd_r, hram_rd_r;
  logic [7:0]  irq_enable_r;
  logic        vram_bank_r;
  logic [2:0]  wram_bank_r;
  logic        video_attached_r;
  logic [15:0] rom_length_r;

  logic        s1_valid_r;
  s1_info_t    s1_r;
  s1_info_t    s1_nxt;
  logic        out_valid_r;
  logic [23:0] out_tdata_r;
  logic [1:0]  out_tuser_r;

  logic        in_acc, s1_move;
  logic [15:0] a;
  logic [7:0]  wd;
  kind_t       kind;
  region_t     region;
  logic        is_rd, is_wr, fwd;
  logic        rom_we, vram_we, wram_we, oam_we, io_we, hram_we, ie_we;
  logic [7:0]  io_wdata;
  logic [VRAM_AW-1:0] vram_idx;
  logic [WRAM_AW-1:0] wram_idx;
  logic [OAM_AW-1:0]  oam_idx;
  logic [IO_AW-1:0]   io_idx;
  logic [7:0]  s1_rdata;

  assign a    = in_tdata[15:0];
  assign wd   = in_tdata[23:16];
  assign kind = kind_t'(in_tuser);

  assign s1_move   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_move;
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign vram_idx = {vram_bank_r, a[12:0]};
  // echo space shares the low 13 bits with 0xC000-0xDFFF; a[12] picks the bank
  assign wram_idx = {(a[12] ? wram_bank_r : 3'd0), a[11:0]};
  assign oam_idx  = a[OAM_AW-1:0];
  assign io_idx   = a[IO_AW-1:0];

  always_comb begin
    region  = decode_region(a);
    is_rd   = (kind == KIND_READ);
    is_wr   = (kind == KIND_WRITE);
    fwd     = video_attached_r && (a >= VID_FIRST) && (a <= VID_LAST) && (is_rd || is_wr);
    rom_we  = 1'b0;
    vram_we = 1'b0;
    wram_we = 1'b0;
    oam_we  = 1'b0;
    io_we   = 1'b0;
    hram_we = 1'b0;
    ie_we   = 1'b0;
    io_wdata = (io_idx == IO_DIV) ? 8'h00 : wd;
    s1_nxt  = '{src: SRC_IMM, imm: 8'h00, vid_access: 1'b0, vid_write: 1'b0,
                vid_reg: 4'h0, vid_wdata: 8'h00};
    if (kind == KIND_LOAD) begin
      rom_we = !a[15];
    end else if (fwd) begin
      s1_nxt.vid_access = 1'b1;
      s1_nxt.vid_write  = is_wr;
      s1_nxt.vid_reg    = a[3:0];
      s1_nxt.vid_wdata  = is_wr ? wd : 8'h00;
    end else if (is_wr) begin
      unique case (region)
        RG_VRAM: vram_we = 1'b1;
        RG_WRAM: wram_we = 1'b1;
        RG_OAM:  oam_we  = 1'b1;
        RG_IO:   io_we   = 1'b1;
        RG_HRAM: hram_we = 1'b1;
        RG_IE:   ie_we   = 1'b1;
        default: ;
      endcase
    end else if (is_rd) begin
      unique case (region)
        RG_ROM: begin
          if (a < rom_length_r) s1_nxt.src = SRC_ROM;
          else s1_nxt.imm = OPEN_BUS;
        end
        RG_VRAM: s1_nxt.src = SRC_VRAM;
        RG_WRAM: s1_nxt.src = SRC_WRAM;
        RG_OAM:  if (oam_vld_r[oam_idx]) s1_nxt.src = SRC_OAM;
        RG_IO:   if (io_vld_r[io_idx]) s1_nxt.src = SRC_IO;
        RG_HRAM: if (hram_vld_r[io_idx]) s1_nxt.src = SRC_HRAM;
        RG_IE:   s1_nxt.imm = irq_enable_r;
        default: s1_nxt.imm = OPEN_BUS;
      endcase
    end
  end

  // storage: one write port and one registered read port each
  always_ff @(posedge clk) begin
    if (in_acc && rom_we) rom_mem[a[ROM_AW-1:0]] <= wd;
    if (in_acc) rom_rd_r <= rom_mem[a[ROM_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (in_acc && vram_we) vram_mem[vram_idx] <= wd;
    if (in_acc) vram_rd_r <= vram_mem[vram_idx];
  end

  always_ff @(posedge clk) begin
    if (in_acc && wram_we) wram_mem[wram_idx] <= wd;
    if (in_acc) wram_rd_r <= wram_mem[wram_idx];
  end

  always_ff @(posedge clk) begin
    if (in_acc && oam_we) oam_mem[oam_idx] <= wd;
    if (in_acc && s1_nxt.src == SRC_OAM) oam_rd_r <= oam_mem[oam_idx];
  end

  always_ff @(posedge clk) begin
    if (in_acc && io_we) io_mem[io_idx] <= io_wdata;
    if (in_acc && s1_nxt.src == SRC_IO) io_rd_r <= io_mem[io_idx];
  end

  always_ff @(posedge clk) begin
    if (in_acc && hram_we) hram_mem[io_idx] <= wd;
    if (in_acc && s1_nxt.src == SRC_HRAM) hram_rd_r <= hram_mem[io_idx];
  end

  // valid bits, bank selects, IE and config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oam_vld_r        <= '0;
      io_vld_r         <= '0;
      hram_vld_r       <= '0;
      irq_enable_r     <= 8'h00;
      vram_bank_r      <= 1'b0;
      wram_bank_r      <= 3'd1;
      video_attached_r <= 1'b0;
      rom_length_r     <= 16'h0000;
    end else begin
      if (in_acc && oam_we) oam_vld_r[oam_idx] <= 1'b1;
      if (in_acc && io_we) begin
        io_vld_r[io_idx] <= 1'b1;
        if (io_idx == IO_VBK) vram_bank_r <= wd[0];
        if (io_idx == IO_SVBK) wram_bank_r <= (wd[2:0] == 3'd0) ? 3'd1 : wd[2:0];
      end
      if (in_acc && hram_we) hram_vld_r[io_idx] <= 1'b1;
      if (in_acc && ie_we) irq_enable_r <= wd;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_VIDEO_ATTACHED: video_attached_r <= cfg_data[0];
          CFG_ROM_LENGTH:     rom_length_r     <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // read stage and output register
  always_comb begin
    case (s1_r.src)
      SRC_ROM:  s1_rdata = rom_rd_r;
      SRC_VRAM: s1_rdata = vram_rd_r;
      SRC_WRAM: s1_rdata = wram_rd_r;
      SRC_OAM:  s1_rdata = oam_rd_r;
      SRC_IO:   s1_rdata = io_rd_r;
      SRC_HRAM: s1_rdata = hram_rd_r;
      default:  s1_rdata = s1_r.imm;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) s1_valid_r <= 1'b1;
      else if (s1_move) s1_valid_r <= 1'b0;
      if (s1_move) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) s1_r <= s1_nxt;
    if (s1_move) begin
      out_tdata_r <= {4'h0, s1_r.vid_wdata, s1_r.vid_reg, s1_rdata};
      out_tuser_r <= {s1_r.vid_write, s1_r.vid_access};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  a_s1_holds_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_valid_r && !out_tready |=> s1_valid_r && $stable(s1_r))
    else $error("read stage lost an item during output stall");

  a_wram_bank_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    wram_bank_r != 3'd0)
    else $error("switchable WRAM bank is zero");

  a_vid_write_needs_access: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_tuser_r[1] && !out_tuser_r[0]))
    else $error("video write flag without video access");

  a_fwd_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_tuser_r[0] |-> out_tdata_r[7:0] == 8'h00)
    else $error("forwarded access carries read data");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r && !s1_valid_r)
    else $error("pipeline not empty after reset");

endmodule

>>> bench/tb_banked_memory_map_bus.sv
`timescale 1ns / 100ps

module tb_banked_memory_map_bus;
  import bmmb_pkg::*;

  localparam logic [1:0]  KIND_NONE   = 2'd3;     // unused kind, does nothing
  localparam logic [15:0] WRAMN_BASE  = 16'hD000;
  localparam logic [15:0] ECHO_BASE   = 16'hE000;
  localparam logic [15:0] OAM_BASE    = 16'hFE00;
  localparam logic [15:0] EMPTY_BASE  = 16'hFEA0;
  localparam logic [15:0] IO_BASE     = 16'hFF00;
  localparam logic [15:0] HRAM_BASE   = 16'hFF80;
  localparam logic [15:0] IE_ADDR     = 16'hFFFF;
  localparam int unsigned HOLD_CYCLES = 300;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] addr;
    logic [7:0]  wdata;
  } access_t;

  typedef struct packed {
    logic [7:0] rdata;
    logic       vid_access;
    logic       vid_write;
    logic [3:0] vid_reg;
    logic [7:0] vid_wdata;
  } bus_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;  // [15:0] addr, [23:16] wdata
  logic [1:0]  in_tuser = '0;  // [1:0] kind
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;      // [7:0] rdata, [11:8] video_reg, [19:12] video_wdata
  logic [1:0]  out_tuser;      // [0] video_access, [1] video_is_write
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_data = '0;

  banked_memory_map_bus i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------- map predictor state ----------------
  bit [7:0]    rom_mem  [ROM_BYTES];
  bit [7:0]    vram_mem [2 * VRAM_BANK_BYTES];
  bit [7:0]    wram_mem [WRAM_BANKS * WRAM_BANK_BYTES];
  bit [7:0]    oam_mem  [OAM_BYTES];
  bit [7:0]    io_mem   [IO_BYTES];
  bit [7:0]    hram_mem [HRAM_BYTES];
  bit [7:0]    ie_reg;
  bit          vram_bank_sel = 1'b0;
  bit [2:0]    wram_bank_sel = 3'd1;
  bit          video_on = 1'b0;
  logic [15:0] rom_length_cfg = '0;

  // stimulus-side view: which entries hold data, and the banks as queued
  bit          rom_written  [ROM_BYTES];
  bit          vram_written [2 * VRAM_BANK_BYTES];
  bit          wram_written [WRAM_BANKS * WRAM_BANK_BYTES];
  bit          queued_vbank = 1'b0;
  bit [2:0]    queued_wbank = 3'd1;

  access_t     pending_accesses [$];
  bus_result_t expected_results [$];
  access_t     offered;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_cnt = 0;
  bit          hold_req = 1'b0;
  int unsigned error_count = 0;

  function automatic logic [13:0] vram_slot(bit bank, logic [15:0] a);
    return {bank, a[12:0]};
  endfunction

  // bit 12 splits bank 0 from the switched bank, for echo addresses too
  function automatic logic [14:0] wram_slot(bit [2:0] bank, logic [15:0] a);
    return a[12] ? {bank, a[11:0]} : {3'd0, a[11:0]};
  endfunction

  function automatic logic [7:0] map_read(logic [15:0] a);
    if (a < VRAM_BASE)       return (a < rom_length_cfg) ? rom_mem[a[14:0]] : OPEN_BUS;
    else if (a < EXT_BASE)   return vram_mem[vram_slot(vram_bank_sel, a)];
    else if (a < WRAM_BASE)  return OPEN_BUS;
    else if (a <= ECHO_END)  return wram_mem[wram_slot(wram_bank_sel, a)];
    else if (a <= OAM_END)   return oam_mem[a - OAM_BASE];
    else if (a <= EMPTY_END) return OPEN_BUS;
    else if (a <= IO_END)    return io_mem[a[6:0]];
    else if (a <= HRAM_END)  return hram_mem[a - HRAM_BASE];
    else                     return ie_reg;
  endfunction

  function automatic void map_write(logic [15:0] a, logic [7:0] v);
    logic [6:0] r;
    r = a[6:0];
    if (a < VRAM_BASE || (a >= EXT_BASE && a < WRAM_BASE)) return;
    if (a < EXT_BASE) vram_mem[vram_slot(vram_bank_sel, a)] = v;
    else if (a <= ECHO_END) wram_mem[wram_slot(wram_bank_sel, a)] = v;
    else if (a <= OAM_END) oam_mem[a - OAM_BASE] = v;
    else if (a <= EMPTY_END) return;
    else if (a <= IO_END) begin
      if (r == IO_DIV) begin
        io_mem[r] = 8'h00;
      end else begin
        io_mem[r] = v;
        if (r == IO_VBK) vram_bank_sel = v[0];
        else if (r == IO_SVBK) wram_bank_sel = (v[2:0] == 3'd0) ? 3'd1 : v[2:0];
      end
    end
    else if (a <= HRAM_END) hram_mem[a - HRAM_BASE] = v;
    else ie_reg = v;
  endfunction

  function automatic bus_result_t apply_access(access_t acc);
    bus_result_t res;
    logic [15:0] a;
    res = '0;
    a = acc.addr;
    case (acc.kind)
      KIND_LOAD: if (a < ROM_BYTES) rom_mem[a[14:0]] = acc.wdata;
      KIND_READ, KIND_WRITE: begin
        if (video_on && a >= VID_FIRST && a <= VID_LAST) begin
          res.vid_access = 1'b1;
          res.vid_write  = (acc.kind == KIND_WRITE);
          res.vid_reg    = 4'(a - VID_FIRST);
          res.vid_wdata  = (acc.kind == KIND_WRITE) ? acc.wdata : 8'h00;
        end else if (acc.kind == KIND_READ) begin
          res.rdata = map_read(a);
        end else begin
          map_write(a, acc.wdata);
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // ---------------- stimulus helpers ----------------
  function automatic bit holds_data(logic [15:0] a);
    if (a < VRAM_BASE) return a >= rom_length_cfg || rom_written[a[14:0]];
    if (a < EXT_BASE) return vram_written[vram_slot(queued_vbank, a)];
    if (a >= WRAM_BASE && a <= ECHO_END) return wram_written[wram_slot(queued_wbank, a)];
    return 1'b1;
  endfunction

  // reads of entries never written turn into the write or load that fills them
  task automatic queue_access(logic [1:0] kind, logic [15:0] a, logic [7:0] v);
    access_t acc;
    if (kind == KIND_READ && !holds_data(a)) kind = (a < VRAM_BASE) ? KIND_LOAD : KIND_WRITE;
    if (kind == KIND_LOAD && a < ROM_BYTES) rom_written[a[14:0]] = 1'b1;
    if (kind == KIND_WRITE) begin
      if (a >= VRAM_BASE && a < EXT_BASE) vram_written[vram_slot(queued_vbank, a)] = 1'b1;
      else if (a >= WRAM_BASE && a <= ECHO_END)
        wram_written[wram_slot(queued_wbank, a)] = 1'b1;
      else if (a == IO_BASE + IO_VBK) queued_vbank = v[0];
      else if (a == IO_BASE + IO_SVBK) queued_wbank = (v[2:0] == 3'd0) ? 3'd1 : v[2:0];
    end
    acc.kind = kind;
    acc.addr = a;
    acc.wdata = v;
    pending_accesses.push_back(acc);
  endtask

  // mostly the first or last few entries of a region, so data gets read back
  function automatic logic [15:0] pick_addr(bit rom_only);
    int unsigned base, span, near, sel;
    case (rom_only ? 0 : $urandom_range(0, 12))
      0:  begin base = 0;          span = ROM_BYTES;       end
      1:  begin base = VRAM_BASE;  span = VRAM_BANK_BYTES; end
      2:  begin base = EXT_BASE;   span = 8192;            end
      3:  begin base = WRAM_BASE;  span = WRAM_BANK_BYTES; end
      4:  begin base = WRAMN_BASE; span = WRAM_BANK_BYTES; end
      5:  begin base = ECHO_BASE;  span = 7680;            end
      6:  begin base = OAM_BASE;   span = OAM_BYTES;       end
      7:  begin base = EMPTY_BASE; span = 96;              end
      8:  begin base = IO_BASE;    span = IO_BYTES;        end
      9:  begin base = VID_FIRST;  span = 12;              end
      10: begin base = HRAM_BASE;  span = HRAM_BYTES;      end
      11: begin
        base = IO_BASE + ($urandom_range(0, 1) ? IO_VBK : IO_SVBK);
        span = 1;
      end
      default: return 16'($urandom);
    endcase
    near = (span > 16) ? 16 : span;
    sel = $urandom_range(0, 9);
    if (sel < 6) return 16'(base + $urandom_range(0, near - 1));
    if (sel < 7) return 16'(base + span - 1 - $urandom_range(0, near - 1));
    return 16'(base + $urandom_range(0, span - 1));
  endfunction

  task automatic queue_random(int unsigned count);
    int unsigned pick;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 45)      queue_access(KIND_READ, pick_addr(1'b0), 8'($urandom));
      else if (pick < 85) queue_access(KIND_WRITE, pick_addr(1'b0), 8'($urandom));
      else if (pick < 97)
        queue_access(KIND_LOAD, $urandom_range(0, 3) ? pick_addr(1'b1) : 16'($urandom),
                     8'($urandom));
      else                queue_access(KIND_NONE, 16'($urandom), 8'($urandom));
    end
  endtask

  task automatic wait_drain();
    while (pending_accesses.size() != 0 || in_tvalid || expected_results.size() != 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(logic idx, logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_VIDEO_ATTACHED) video_on = val[0];
    else rom_length_cfg = val;
    cfg_valid <= 1'b0;
  endtask

  task automatic set_idle(int unsigned send_pct, int unsigned recv_pct);
    send_idle_pct = send_pct;
    stall_pct = recv_pct;
  endtask

  task automatic report_mismatch(string what);
    $display("ERROR at %0t: %s", $time, what);
    error_count++;
  endtask

  // ---------------- driver ----------------
  always @(posedge clk) begin
    bit busy;
    if (rst_n) begin
      busy = in_tvalid;
      if (in_tvalid && in_tready) begin
        expected_results.push_back(apply_access(offered));
        busy = 1'b0;
      end
      if (!busy) begin
        if (pending_accesses.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          offered = pending_accesses.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {offered.wdata, offered.addr};
          in_tuser  <= offered.kind;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, counted here
  always @(posedge clk) begin
    if (hold_cnt != 0) hold_cnt <= hold_cnt - 1;
    else if (hold_req) hold_cnt <= HOLD_CYCLES;
  end

  // ---------------- monitor ----------------
  always @(posedge clk) begin
    bus_result_t got, want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got.rdata      = out_tdata[7:0];
        got.vid_reg    = out_tdata[11:8];
        got.vid_wdata  = out_tdata[19:12];
        got.vid_access = out_tuser[0];
        got.vid_write  = out_tuser[1];
        if (expected_results.size() == 0) begin
          report_mismatch("result item with nothing expected");
        end else begin
          want = expected_results.pop_front();
          if (got.rdata !== want.rdata)
            report_mismatch($sformatf("rdata %h, expected %h", got.rdata, want.rdata));
          if (got.vid_access !== want.vid_access)
            report_mismatch($sformatf("video_access %b, expected %b",
                                      got.vid_access, want.vid_access));
          if (got.vid_write !== want.vid_write)
            report_mismatch($sformatf("video_is_write %b, expected %b",
                                      got.vid_write, want.vid_write));
          if (got.vid_reg !== want.vid_reg)
            report_mismatch($sformatf("video_reg %h, expected %h", got.vid_reg, want.vid_reg));
          if (got.vid_wdata !== want.vid_wdata)
            report_mismatch($sformatf("video_wdata %h, expected %h",
                                      got.vid_wdata, want.vid_wdata));
        end
      end
      out_tready <= (hold_cnt == 0) && ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // ---------------- sequence ----------------
  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset config: detached video, empty ROM
    queue_access(KIND_READ,  16'h0000, 8'h00);   // past rom_length
    queue_access(KIND_LOAD,  16'h0000, 8'hA5);
    queue_access(KIND_LOAD,  16'h7FFF, 8'h5A);
    queue_access(KIND_LOAD,  16'h8000, 8'h11);   // out of range, dropped
    queue_access(KIND_WRITE, 16'h0000, 8'h33);   // ROM ignores writes
    queue_access(KIND_WRITE, 16'h8000, 8'h01);
    queue_access(KIND_WRITE, 16'h9FFF, 8'hFE);
    queue_access(KIND_WRITE, IO_BASE + IO_VBK, 8'hFF);
    queue_access(KIND_WRITE, 16'h8000, 8'h77);
    queue_access(KIND_READ,  16'h8000, 8'h00);
    queue_access(KIND_READ,  IO_BASE + IO_VBK, 8'h00);
    queue_access(KIND_WRITE, IO_BASE + IO_VBK, 8'h00);
    queue_access(KIND_READ,  16'h9FFF, 8'h00);
    queue_access(KIND_WRITE, EXT_BASE, 8'h55);
    queue_access(KIND_READ,  16'hBFFF, 8'h00);
    queue_access(KIND_WRITE, WRAM_BASE, 8'h12);
    queue_access(KIND_READ,  ECHO_BASE, 8'h00);
    queue_access(KIND_WRITE, IO_BASE + IO_SVBK, 8'h07);
    queue_access(KIND_WRITE, 16'hDDFF, 8'h56);
    queue_access(KIND_READ,  ECHO_END, 8'h00);
    queue_access(KIND_WRITE, IO_BASE + IO_SVBK, 8'hF8);  // bank 0 acts as 1
    queue_access(KIND_WRITE, WRAMN_BASE, 8'h34);
    queue_access(KIND_READ,  16'hF000, 8'h00);
    queue_access(KIND_WRITE, IO_BASE + IO_DIV, 8'hAB);
    queue_access(KIND_READ,  IO_BASE + IO_DIV, 8'h00);
    queue_access(KIND_READ,  OAM_END, 8'h00);
    queue_access(KIND_READ,  EMPTY_BASE, 8'h00);
    queue_access(KIND_WRITE, IE_ADDR, 8'hC3);
    queue_access(KIND_READ,  IE_ADDR, 8'h00);
    queue_access(KIND_WRITE, VID_LAST, 8'h99);   // plain register while detached
    queue_access(KIND_READ,  VID_LAST, 8'h00);
    queue_access(KIND_NONE,  16'hFFFF, 8'hFF);
    wait_drain();

    write_register(CFG_VIDEO_ATTACHED, 16'd1);
    write_register(CFG_ROM_LENGTH, 16'hFFFF);    // above ROM size
    queue_access(KIND_READ,  16'h0000, 8'h00);
    queue_access(KIND_READ,  16'h7FFF, 8'h00);
    queue_access(KIND_READ,  VID_FIRST, 8'h00);
    queue_access(KIND_WRITE, VID_LAST, 8'h3C);
    queue_access(KIND_READ,  VID_LAST + 16'd1, 8'h00);
    queue_random(250);
    wait_drain();

    write_register(CFG_VIDEO_ATTACHED, 16'd0);
    write_register(CFG_ROM_LENGTH, 16'h8000);
    set_idle(53, 0);
    queue_random(250);
    wait_drain();

    write_register(CFG_VIDEO_ATTACHED, 16'd1);
    write_register(CFG_ROM_LENGTH, 16'h0000);
    set_idle(0, 53);
    queue_random(250);
    wait_drain();

    write_register(CFG_ROM_LENGTH, 16'($urandom_range(1, ROM_BYTES - 1)));
    set_idle(26, 26);
    queue_random(250);
    wait_drain();

    // receiver holds off while the sender keeps offering: block fills up
    write_register(CFG_VIDEO_ATTACHED, 16'd0);
    write_register(CFG_ROM_LENGTH, 16'h4000);
    set_idle(0, 0);
    hold_req <= 1'b1;
    queue_random(150);
    while (hold_cnt == 0) @(negedge clk);
    hold_req <= 1'b0;
    wait_drain();

    write_register(CFG_VIDEO_ATTACHED, 16'($urandom_range(0, 1)));
    write_register(CFG_ROM_LENGTH, 16'($urandom));
    set_idle(26, 26);
    queue_random(250);
    wait_drain();

    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_banked_memory_map_bus: done, clean");
    end else begin
      $display("tb_banked_memory_map_bus: done, errors");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("timeout");
    $display("tb_banked_memory_map_bus: done, errors");
    $finish;
  end

endmodule
